// File: design/gps_pkg.sv
// Shared constants and item types for the polar Gaussian sampler.
// No dependencies; every design file imports it.
package gps_pkg;

  // width of one uniform word in use
  localparam int UNIFORM_BITS = 16;
  localparam int UNI_W        = UNIFORM_BITS;

  // squared radius: r = rr / 2^S_VAL
  localparam int RR_W  = 2 * UNI_W;
  localparam int S_VAL = 2 * UNI_W - 2;
  localparam int E_W   = $clog2(RR_W);

  // normalised mantissa, Q30 in [1,2)
  localparam int M_W      = 31;
  localparam int LOG_FRAC = 24;
  localparam int LQ_W     = $clog2(S_VAL + 1) + LOG_FRAC;
  localparam int T_W      = LQ_W + 2;

  // divider and square root
  localparam int DIV_SH = 46;
  localparam int Q_W    = T_W + DIV_SH - (M_W - 1);
  localparam int V_W    = Q_W + (Q_W % 2);
  localparam int R_W    = V_W / 2;
  localparam int RS_W   = $clog2(UNI_W + 4);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b1;

  // signs and magnitudes that ride alongside the arithmetic
  typedef struct packed {
    logic             sgn_x;
    logic             sgn_y;
    logic [UNI_W-1:0] ax;
    logic [UNI_W-1:0] ay;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [E_W-1:0] e;
    logic [M_W-1:0] m;
  } norm_t;

  typedef struct packed {
    norm_t               base;
    logic [M_W-1:0]      ml;
    logic [LOG_FRAC-1:0] f;
  } log_t;

  typedef struct packed {
    side_t           side;
    logic [RS_W-1:0] rs;
    logic [M_W-1:0]  m;
    logic [T_W-1:0]  t;
  } dvin_t;

  typedef struct packed {
    side_t           side;
    logic [RS_W-1:0] rs;
    logic [R_W-1:0]  q;
  } dvout_t;

endpackage

// File: design/gps_log2.sv
// Pipelined log2 of the normalised radius: one squaring stage per fraction bit.
// Depends on gps_pkg.
module gps_log2 import gps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  norm_t in_data,
  output logic  out_vld,
  output log_t  out_data
);

  log_t              st_r [LOG_FRAC];
  log_t              src  [LOG_FRAC];
  logic [LOG_FRAC-1:0] v_r;
  logic [LOG_FRAC-1:0] src_v;

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic [2*M_W-1:0] prod;
    logic [M_W:0]     sq;
    log_t             nxt;

    if (g == 0) begin : g_first
      assign src[g]   = '{base: in_data, ml: in_data.m, f: '0};
      assign src_v[g] = in_vld;
    end else begin : g_rest
      assign src[g]   = st_r[g-1];
      assign src_v[g] = v_r[g-1];
    end

    // square, renormalise, one fraction bit out
    always_comb begin
      prod = src[g].ml * src[g].ml;
      sq   = prod[2*M_W-1:M_W-1];
      nxt  = src[g];
      if (sq[M_W]) begin
        nxt.ml                 = sq[M_W:1];
        nxt.f[LOG_FRAC-1-g]    = 1'b1;
      end else begin
        nxt.ml = sq[M_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= src_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= nxt;
      end
    end
  end

  assign out_vld  = v_r[LOG_FRAC-1];
  assign out_data = st_r[LOG_FRAC-1];

endmodule

// File: design/gps_divsqrt.sv
// Pipelined restoring divider (t * 2^46 / m) followed by a digit-by-digit
// square root, one quotient bit or one root bit per stage. Depends on gps_pkg.
module gps_divsqrt import gps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  dvin_t  in_data,
  output logic   out_vld,
  output dvout_t out_data
);

  typedef struct packed {
    side_t           side;
    logic [RS_W-1:0] rs;
    logic [M_W-1:0]  m;
    logic [M_W-1:0]  rem;
    logic [Q_W-1:0]  dq;
  } div_st_t;

  typedef struct packed {
    side_t           side;
    logic [RS_W-1:0] rs;
    logic [R_W+1:0]  srem;
    logic [R_W-1:0]  root;
    logic [V_W-1:0]  vs;
  } sq_st_t;

  div_st_t        dv_r  [Q_W];
  div_st_t        dsrc  [Q_W];
  logic [Q_W-1:0] dv_v_r;
  logic [Q_W-1:0] dsrc_v;

  sq_st_t         sq_r  [R_W];
  sq_st_t         ssrc  [R_W];
  logic [R_W-1:0] sq_v_r;
  logic [R_W-1:0] ssrc_v;

  logic [T_W+DIV_SH-1:0] dd;

  // dividend split: high bits seed the remainder, the rest shift in
  assign dd = {in_data.t, {DIV_SH{1'b0}}};

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    logic [M_W:0] cand;
    logic [M_W:0] diff;
    logic         ge;
    div_st_t      nxt;

    if (g == 0) begin : g_first
      assign dsrc[g] = '{side: in_data.side, rs: in_data.rs, m: in_data.m,
                         rem: M_W'(dd[T_W+DIV_SH-1:Q_W]), dq: dd[Q_W-1:0]};
      assign dsrc_v[g] = in_vld;
    end else begin : g_rest
      assign dsrc[g]   = dv_r[g-1];
      assign dsrc_v[g] = dv_v_r[g-1];
    end

    // compare and subtract
    always_comb begin
      cand    = {dsrc[g].rem, dsrc[g].dq[Q_W-1]};
      diff    = cand - {1'b0, dsrc[g].m};
      ge      = (cand >= {1'b0, dsrc[g].m});
      nxt     = dsrc[g];
      nxt.rem = ge ? diff[M_W-1:0] : cand[M_W-1:0];
      nxt.dq  = {dsrc[g].dq[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[g] <= 1'b0;
      end else if (en) begin
        dv_v_r[g] <= dsrc_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g] <= nxt;
      end
    end
  end

  for (genvar g = 0; g < R_W; g++) begin : g_sqrt
    logic [R_W+3:0] cand;
    logic [R_W+3:0] trial;
    logic [R_W+3:0] diff;
    logic           ge;
    sq_st_t         nxt;

    if (g == 0) begin : g_first
      assign ssrc[g] = '{side: dv_r[Q_W-1].side, rs: dv_r[Q_W-1].rs, srem: '0,
                         root: '0, vs: V_W'(dv_r[Q_W-1].dq)};
      assign ssrc_v[g] = dv_v_r[Q_W-1];
    end else begin : g_rest
      assign ssrc[g]   = sq_r[g-1];
      assign ssrc_v[g] = sq_v_r[g-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      cand     = {ssrc[g].srem, ssrc[g].vs[V_W-1:V_W-2]};
      trial    = {2'b00, ssrc[g].root, 2'b01};
      diff     = cand - trial;
      ge       = (cand >= trial);
      nxt      = ssrc[g];
      nxt.srem = ge ? diff[R_W+1:0] : cand[R_W+1:0];
      nxt.root = {ssrc[g].root[R_W-2:0], ge};
      nxt.vs   = {ssrc[g].vs[V_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g] <= 1'b0;
      end else if (en) begin
        sq_v_r[g] <= ssrc_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g] <= nxt;
      end
    end
  end

  assign out_vld  = sq_v_r[R_W-1];
  assign out_data = '{side: sq_r[R_W-1].side, rs: sq_r[R_W-1].rs,
                      q: sq_r[R_W-1].root};

endmodule

// File: design/gaussian_polar_sampler.sv
// Top level of the polar-method Gaussian sampler: input decode, radius test,
// log/scale stages, output pair buffer. Depends on gps_pkg, gps_log2, gps_divsqrt.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_tvalid/in_tready  | in_tdata: uniform_x, uniform_y
//   out_    | out       | out_tvalid/out_tready| out_tdata: normal_value; out_tlast: is_last
//   cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One uniform pair is taken every cycle while the output buffer lets the pipeline
// advance; an accepted pair leaves as two items, so the output port sets the rate.
// The pipeline is 3 + 24 + 2 + Q_W + R_W + 3 stages (103 for 16-bit words) plus the
// output buffer: one stage per log bit, quotient bit and root bit.
// rst_n clears all valid bits and loads mean 0 and scale 1.0.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module gaussian_polar_sampler import gps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [15:0] uniform_x, [31:16] uniform_y
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [31:0] normal_value
  output logic                 out_tlast,  // is_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int PR_W  = UNI_W + R_W;
  localparam int MAG_W = 24;
  localparam int SCL_W = MAG_W + 31 - 16;
  localparam int VAL_W = SCL_W + 2;
  localparam logic [UNI_W-1:0] HALF   = {1'b1, {(UNI_W-1){1'b0}}};
  localparam logic [RR_W-1:0]  RR_LIM = {2'b01, {S_VAL{1'b0}}};
  localparam logic [30:0]      TWO_LN2_Q30 = 31'd1488522236;

  // configuration
  logic signed [31:0] mean_r;
  logic [30:0]        scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      scale_r <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MEAN:  mean_r  <= cfg_data;
        REG_SCALE: scale_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign in_tready = adv;

  // stage A: offset-binary words to sign and magnitude
  logic [UNI_W-1:0] ux, uy;
  side_t            a_nxt, a_r;
  logic             a_v_r;

  always_comb begin
    ux          = UNI_W'(in_tdata[15:0]);
    uy          = UNI_W'(in_tdata[31:16]);
    a_nxt.sgn_x = !ux[UNI_W-1];
    a_nxt.sgn_y = !uy[UNI_W-1];
    a_nxt.ax    = ux[UNI_W-1] ? {1'b0, ux[UNI_W-2:0]} : HALF - ux;
    a_nxt.ay    = uy[UNI_W-1] ? {1'b0, uy[UNI_W-2:0]} : HALF - uy;
  end

  // stage B: squared radius and reject test
  logic [RR_W-1:0] b_rr_nxt, b_rr_r;
  side_t           b_side_r;
  logic            b_v_r;

  assign b_rr_nxt = RR_W'(a_r.ax) * RR_W'(a_r.ax) + RR_W'(a_r.ay) * RR_W'(a_r.ay);

  // stage C: leading one and normalise to Q30
  logic [E_W-1:0]  c_e;
  logic [RR_W-1:0] c_norm;
  norm_t           c_r;
  logic            c_v_r;

  always_comb begin
    c_e = '0;
    for (int k = 0; k < RR_W; k++) begin
      if (b_rr_r[k]) c_e = E_W'(k);
    end
    c_norm = b_rr_r << (E_W'(RR_W - 1) - c_e);
  end

  // log2 pipeline
  logic l_v;
  log_t l_d;

  gps_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (c_v_r),
    .in_data (c_r),
    .out_vld (l_v),
    .out_data(l_d)
  );

  // stage L: -log2(r) in Q24
  logic [E_W-1:0]  w_nxt, d_w_r;
  logic [LQ_W-1:0] lq_nxt, d_lq_r;
  side_t           d_side_r;
  logic [M_W-1:0]  d_m_r;
  logic            d_v_r;

  always_comb begin
    w_nxt  = E_W'(S_VAL) - l_d.base.e;
    lq_nxt = (LQ_W'(w_nxt) << LOG_FRAC) - LQ_W'(l_d.f);
  end

  // stage T: times 2 ln 2, fold odd exponent
  logic [LQ_W+30:0] t_prod;
  logic [T_W-1:0]   t_raw;
  dvin_t            t_nxt, t_r;
  logic             t_v_r;

  always_comb begin
    t_prod      = LQ_W'(d_lq_r) * (LQ_W + 31)'(TWO_LN2_Q30);
    t_raw       = T_W'(t_prod >> 30);
    t_nxt.side  = d_side_r;
    t_nxt.m     = d_m_r;
    t_nxt.t     = d_w_r[0] ? (t_raw << 1) : t_raw;
    t_nxt.rs    = RS_W'(UNI_W + 3) - RS_W'(d_w_r >> 1);
  end

  // divider and square root pipeline
  logic   q_v;
  dvout_t q_d;

  gps_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (t_v_r),
    .in_data (t_r),
    .out_vld (q_v),
    .out_data(q_d)
  );

  // stage P: |s| * q for both lanes
  logic [PR_W-1:0] p_x_r, p_y_r;
  logic [RS_W-1:0] p_rs_r;
  logic            p_sx_r, p_sy_r, p_v_r;

  // stage N: round half up and shift
  logic [PR_W:0]    n_rnd;
  logic [MAG_W-1:0] n_x_nxt, n_y_nxt, n_x_r, n_y_r;
  logic             n_sx_r, n_sy_r, n_v_r;

  always_comb begin
    n_rnd   = (PR_W + 1)'(1) << (p_rs_r - RS_W'(1));
    n_x_nxt = MAG_W'(({1'b0, p_x_r} + n_rnd) >> p_rs_r);
    n_y_nxt = MAG_W'(({1'b0, p_y_r} + n_rnd) >> p_rs_r);
  end

  // stage S: standard deviation scale
  logic [MAG_W+30:0] s_px, s_py;
  logic [SCL_W-1:0]  s_x_r, s_y_r;
  logic              s_sx_r, s_sy_r, s_v_r;

  always_comb begin
    s_px = (MAG_W + 31)'(n_x_r) * (MAG_W + 31)'(scale_r) + (MAG_W + 31)'(32768);
    s_py = (MAG_W + 31)'(n_y_r) * (MAG_W + 31)'(scale_r) + (MAG_W + 31)'(32768);
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      t_v_r <= 1'b0;
      p_v_r <= 1'b0;
      n_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r && (b_rr_nxt != '0) && (b_rr_nxt <= RR_LIM);
      c_v_r <= b_v_r;
      d_v_r <= l_v;
      t_v_r <= d_v_r;
      p_v_r <= q_v;
      n_v_r <= p_v_r;
      s_v_r <= n_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= a_nxt;
      b_rr_r   <= b_rr_nxt;
      b_side_r <= a_r;
      c_r.side <= b_side_r;
      c_r.e    <= c_e;
      c_r.m    <= M_W'({c_norm, {M_W{1'b0}}} >> RR_W);
      d_w_r    <= w_nxt;
      d_lq_r   <= lq_nxt;
      d_side_r <= l_d.base.side;
      d_m_r    <= l_d.base.m;
      t_r      <= t_nxt;
      p_x_r    <= PR_W'(q_d.side.ax) * PR_W'(q_d.q);
      p_y_r    <= PR_W'(q_d.side.ay) * PR_W'(q_d.q);
      p_rs_r   <= q_d.rs;
      p_sx_r   <= q_d.side.sgn_x;
      p_sy_r   <= q_d.side.sgn_y;
      n_x_r    <= n_x_nxt;
      n_y_r    <= n_y_nxt;
      n_sx_r   <= p_sx_r;
      n_sy_r   <= p_sy_r;
      s_x_r    <= SCL_W'(s_px >> 16);
      s_y_r    <= SCL_W'(s_py >> 16);
      s_sx_r   <= n_sx_r;
      s_sy_r   <= n_sy_r;
    end
  end

  // apply sign, add mean, saturate to 32 bits
  function automatic logic [31:0] sat_out(input logic neg, input logic [SCL_W-1:0] mag,
                                          input logic signed [31:0] mean);
    logic signed [VAL_W-1:0] sv;
    logic signed [VAL_W-1:0] val;
    logic [31:0]             res;
    sv  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    val = sv + VAL_W'(mean);
    if (val[VAL_W-1] && !(&val[VAL_W-2:31])) begin
      res = 32'h8000_0000;
    end else if (!val[VAL_W-1] && (|val[VAL_W-2:31])) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

  // output pair buffer: x first, then y with tlast
  logic [31:0] ob_x_r, ob_y_r;
  logic        ob_full_r, ob_ph_r;

  assign adv        = !ob_full_r || (out_tready && ob_ph_r);
  assign out_tvalid = ob_full_r;
  assign out_tdata  = ob_ph_r ? ob_y_r : ob_x_r;
  assign out_tlast  = ob_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_full_r <= 1'b0;
      ob_ph_r   <= 1'b0;
    end else if (adv && s_v_r) begin
      ob_full_r <= 1'b1;
      ob_ph_r   <= 1'b0;
    end else if (ob_full_r && out_tready) begin
      if (ob_ph_r) begin
        ob_full_r <= 1'b0;
        ob_ph_r   <= 1'b0;
      end else begin
        ob_ph_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_v_r) begin
      ob_x_r <= sat_out(s_sx_r, s_x_r, mean_r);
      ob_y_r <= sat_out(s_sy_r, s_y_r, mean_r);
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the polar Gaussian sampler: directed pairs, then random pairs.
// Depends on gps_pkg and the gaussian_polar_sampler RTL only.
module tb_top;
  import gps_pkg::*;

  localparam int HALF_SCALE = 1 << (UNIFORM_BITS - 1);
  localparam int DRAIN_WAIT = 200;
  localparam int STALL_LEN  = 400;
  localparam int WDOG_LIMIT = 5000;
  localparam longint unsigned TWO_LN2 = 64'd1488522236;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sample_t;

  // directed row: fixed rows carry their expectation, others go to the predictor
  typedef struct {
    logic [15:0] ux;
    logic [15:0] uy;
    bit          fixed;
    int          n_res;
    logic [31:0] v0;
    logic [31:0] v1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MEAN;
  logic [31:0] cfg_data = '0;

  sample_t     pending_samples[$];
  int          error_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          stall_asks = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  logic signed [31:0] mean_reg;
  logic [30:0]        scale_reg;

  gaussian_polar_sampler u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // scale, add mean, saturate
  function automatic logic [31:0] scale_and_offset(input bit neg, input longint unsigned mag);
    longint unsigned scaled;
    longint          val;
    scaled = (mag * longint'(scale_reg) + (64'd1 << 15)) >> 16;
    val = neg ? -longint'(scaled) : longint'(scaled);
    val += longint'(mean_reg);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    return val[31:0];
  endfunction

  // queue the samples that one uniform pair should produce
  task automatic polar_predict(input logic [15:0] ux, input logic [15:0] uy);
    longint sx, sy;
    longint unsigned ax, ay, rr, m, f, lq, t, num, qv, rem, v, q, prod;
    int e, w, rs, s_bits;
    sample_t smp;
    s_bits = 2 * UNIFORM_BITS - 2;
    sx = longint'(ux) - HALF_SCALE;
    sy = longint'(uy) - HALF_SCALE;
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    rr = ax * ax + ay * ay;
    if (rr == 0 || rr > (64'd1 << s_bits)) return;
    e = 0;
    while (e < 63 && (rr >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (rr >> (e - 30)) : (rr << (30 - e));
    f = 0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        f |= 64'd1 << (LOG_FRAC - 1 - i);
      end
    end
    m = (e >= 30) ? (rr >> (e - 30)) : (rr << (30 - e));
    lq = (longint'(s_bits) << LOG_FRAC) - ((longint'(e) << LOG_FRAC) + f);
    t = (lq * TWO_LN2) >> 30;
    w = s_bits - e;
    if (w % 2) begin
      t <<= 1;
      w -= 1;
    end
    num = t << 30;
    qv = num / m;
    rem = num % m;
    v = (qv << 16) + ((rem << 16) / m);
    q = int_sqrt(v);
    rs = UNIFORM_BITS + 3 - w / 2;
    prod = ax * q;
    smp.value = scale_and_offset(sx < 0, (prod + (64'd1 << (rs - 1))) >> rs);
    smp.last = 1'b0;
    pending_samples.push_back(smp);
    prod = ay * q;
    smp.value = scale_and_offset(sy < 0, (prod + (64'd1 << (rs - 1))) >> rs);
    smp.last = 1'b1;
    pending_samples.push_back(smp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MEAN) mean_reg = data;
    else scale_reg = data[30:0];
  endtask

  // offer one pair; returns once the block has taken it
  task automatic send_pair(input logic [15:0] ux, input logic [15:0] uy);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {uy, ux};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender until every sample is out and the pipeline has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // random pair: mostly uniform, some near the centre, some near the unit circle
  task automatic random_pair(output logic [15:0] ux, output logic [15:0] uy);
    int sel, ang;
    sel = $urandom_range(9);
    if (sel < 6) begin
      ux = 16'($urandom);
      uy = 16'($urandom);
    end else if (sel < 8) begin
      ux = 16'(HALF_SCALE + $urandom_range(64) - 32);
      uy = 16'(HALF_SCALE + $urandom_range(64) - 32);
    end else begin
      ang = $urandom_range(23170);
      ux = $urandom_range(1) ? 16'(HALF_SCALE + ang) : 16'(HALF_SCALE - ang);
      uy = 16'(HALF_SCALE + (($urandom_range(1) ? 1 : -1) *
           (int'(int_sqrt(64'd1073741824 - ang * ang)) - $urandom_range(3))));
    end
  endtask

  // result side: check each taken sample, then pick next ready
  always @(posedge clk) begin
    sample_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_samples.size() == 0) begin
          report("unexpected sample", out_tdata, '0);
        end else begin
          want = pending_samples.pop_front();
          if (out_tdata !== want.value) report("normal_value", out_tdata, want.value);
          if (out_tlast !== want.last) report("is_last", 32'(out_tlast), 32'(want.last));
        end
      end
      if (stall_seen != stall_asks) begin
        stall_seen <= stall_asks;
        stall_left <= STALL_LEN;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    logic [15:0] ux, uy;
    sample_t smp;
    logic [31:0] phase_mean[5];
    logic [31:0] phase_scale[5];

    // radius exactly one: both samples equal the mean (0 after reset)
    dir_rows.push_back('{16'h0000, 16'h8000, 1, 2, 32'h0, 32'h0});
    dir_rows.push_back('{16'h8000, 16'h0000, 1, 2, 32'h0, 32'h0});
    // zero radius and radius above one are dropped
    dir_rows.push_back('{16'h8000, 16'h8000, 1, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h0000, 16'h0000, 1, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'hFFFF, 16'hFFFF, 1, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h0000, 16'hFFFF, 1, 0, 32'h0, 32'h0});
    // extremes and tiny radii, predicted
    dir_rows.push_back('{16'hFFFF, 16'h8000, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h8000, 16'hFFFF, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h8001, 16'h8000, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h7FFF, 16'h7FFF, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h8001, 16'h7FFF, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h2000, 16'hE000, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'hA5A5, 16'h5A5A, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'h5A5A, 16'hA5A5, 0, 0, 32'h0, 32'h0});
    dir_rows.push_back('{16'hC000, 16'h4000, 0, 0, 32'h0, 32'h0});

    phase_mean  = '{32'h0, 32'h7FFFFFFF, 32'h80000000, $urandom, 32'hFFFB0000};
    phase_scale = '{32'h10000, 32'h7FFFFFFF, 32'h0, $urandom, 32'h30000};
    mean_reg  = 0;
    scale_reg = 31'h10000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 34 : 0;
      if (ph > 0) begin
        write_reg(REG_MEAN, phase_mean[ph]);
        write_reg(REG_SCALE, phase_scale[ph]);
      end
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          send_pair(dir_rows[i].ux, dir_rows[i].uy);
          if (dir_rows[i].fixed) begin
            if (dir_rows[i].n_res == 2) begin
              smp = '{dir_rows[i].v0, 1'b0};
              pending_samples.push_back(smp);
              smp = '{dir_rows[i].v1, 1'b1};
              pending_samples.push_back(smp);
            end
          end else begin
            polar_predict(dir_rows[i].ux, dir_rows[i].uy);
          end
        end
      end
      for (int k = 0; k < 300; k++) begin
        if (ph == 4 && k == 10) stall_asks++;
        random_pair(ux, uy);
        send_pair(ux, uy);
        polar_predict(ux, uy);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
